### sv/dnsp_pkg.sv
// Shared types and constants for the DNS message field parser.
// No dependencies.
package dnsp_pkg;

	localparam int MAX_NAME_BYTES_DEF = 255;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [7:0] PTR_MARK = 8'hc0;

	localparam logic [2:0] SEC_HDR = 3'd0;
	localparam logic [2:0] SEC_TRAIL = 3'd5;

	localparam logic [3:0] FK_NAME = 4'd6;
	localparam logic [3:0] FK_TYPE = 4'd7;
	localparam logic [3:0] FK_CLASS = 4'd8;
	localparam logic [3:0] FK_TTL = 4'd9;
	localparam logic [3:0] FK_RDLEN = 4'd10;
	localparam logic [3:0] FK_RDATA = 4'd11;
	localparam logic [3:0] FK_EXTRA = 4'd12;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	typedef enum logic [7:0] {
		PH_HDR   = 8'b0000_0001,
		PH_NAME  = 8'b0000_0010,
		PH_TYPE  = 8'b0000_0100,
		PH_CLASS = 8'b0000_1000,
		PH_TTL   = 8'b0001_0000,
		PH_RDLEN = 8'b0010_0000,
		PH_RDATA = 8'b0100_0000,
		PH_DONE  = 8'b1000_0000
	} phase_t;

	// One tagged byte, as it leaves the classifier.
	typedef struct packed {
		logic [2:0]  section;
		logic [3:0]  field_kind;
		logic        value_valid;
		logic [31:0] field_value;
		logic [15:0] record_index;
		logic        record_end;
		logic        name_pointer;
		logic        message_done;
		logic [1:0]  status;
	} tag_t;

endpackage

### sv/dnsp_front.sv
// Classifier: walks the DNS wire format one byte per cycle while step is high and tags each byte.
// Depends on dnsp_pkg.
module dnsp_front #(
	parameter int MAX_NAME_BYTES = dnsp_pkg::MAX_NAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output dnsp_pkg::tag_t tag
);
	import dnsp_pkg::*;

	phase_t      phase_q;
	logic [3:0]  bif_q;
	logic [31:0] acc_q;
	logic [15:0] rem_q [4];
	logic [15:0] entry_q;
	logic [5:0]  lab_q;
	logic [8:0]  nbs_q;
	logic [15:0] drem_q;
	logic [1:0]  sec_q;

	phase_t      phase_d;
	logic [3:0]  bif_d;
	logic [31:0] acc_d;
	logic [15:0] rem_d [4];
	logic [15:0] entry_d;
	logic [5:0]  lab_d;
	logic [8:0]  nbs_d;
	logic [15:0] drem_d;
	logic [1:0]  sec_d;
	logic        fin;
	logic        hdr_enter;
	logic [2:0]  first_s;
	logic [15:0] drem_dec;

	always_comb begin
		logic [2:0] s;
		logic       found;
		logic [1:0] cs;
		logic [31:0] shv;
		phase_d = phase_q;
		bif_d   = bif_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		entry_d = entry_q;
		lab_d   = lab_q;
		nbs_d   = nbs_q;
		drem_d  = drem_q;
		sec_d   = sec_q;
		tag     = '0;
		fin     = 1'b0;
		hdr_enter = 1'b0;
		drem_dec = drem_q;
		cs = sec_q;
		shv = (bif_q == 4'd0) ? {24'd0, in_byte} : {acc_q[23:0], in_byte};
		case (phase_q)
			PH_HDR: begin
				tag.field_kind = bif_q >> 1;
				if (!bif_q[0]) begin
					acc_d = {24'd0, in_byte};
				end else begin
					acc_d = {16'd0, acc_q[7:0], in_byte};
					tag.value_valid = 1'b1;
					tag.field_value = acc_d;
					if (bif_q >= 4'd3)
						rem_d[2'((bif_q >> 1) - 4'd2)] = acc_d[15:0];
				end
				bif_d = bif_q + 4'd1;
				if (bif_d >= 4'd12) hdr_enter = 1'b1;
			end
			PH_NAME: begin
				tag.section = {1'b0, sec_q} + 3'd1;
				tag.field_kind = FK_NAME;
				tag.record_index = entry_q;
				if (nbs_q >= 9'(MAX_NAME_BYTES)) tag.status = ST_LONG;
				if (nbs_q < 9'd511) nbs_d = nbs_q + 9'd1;
				if (bif_q == 4'd1) begin
					tag.name_pointer = 1'b1;
					phase_d = PH_TYPE;
					bif_d = '0;
				end else if (lab_q != 6'd0) begin
					lab_d = lab_q - 6'd1;
				end else if (in_byte == 8'd0) begin
					phase_d = PH_TYPE;
					bif_d = '0;
				end else if ((in_byte & PTR_MARK) == PTR_MARK) begin
					tag.name_pointer = 1'b1;
					bif_d = 4'd1;
				end else begin
					lab_d = in_byte[5:0];
				end
			end
			PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
				tag.section = {1'b0, sec_q} + 3'd1;
				tag.record_index = entry_q;
				tag.field_kind = (phase_q == PH_TYPE) ? FK_TYPE :
					(phase_q == PH_CLASS) ? FK_CLASS :
					(phase_q == PH_TTL) ? FK_TTL : FK_RDLEN;
				acc_d = shv;
				bif_d = bif_q + 4'd1;
				if (bif_d >= ((phase_q == PH_TTL) ? 4'd4 : 4'd2)) begin
					tag.value_valid = 1'b1;
					tag.field_value = shv;
					bif_d = '0;
					case (phase_q)
						PH_TYPE: phase_d = PH_CLASS;
						PH_CLASS: begin
							if (sec_q == 2'd0) begin
								tag.record_end = 1'b1;
								fin = 1'b1;
							end else begin
								phase_d = PH_TTL;
							end
						end
						PH_TTL: phase_d = PH_RDLEN;
						default: begin
							drem_d = shv[15:0];
							if (shv[15:0] == 16'd0) begin
								tag.record_end = 1'b1;
								fin = 1'b1;
							end else begin
								phase_d = PH_RDATA;
							end
						end
					endcase
				end
			end
			PH_RDATA: begin
				tag.section = {1'b0, sec_q} + 3'd1;
				tag.field_kind = FK_RDATA;
				tag.record_index = entry_q;
				if (drem_q != 16'd0) drem_dec = drem_q - 16'd1;
				drem_d = drem_dec;
				if (drem_dec == 16'd0) begin
					tag.record_end = 1'b1;
					fin = 1'b1;
				end
			end
			default: begin
				tag.section = SEC_TRAIL;
				tag.field_kind = FK_EXTRA;
				phase_d = PH_DONE;
			end
		endcase

		// record completion and section entry
		first_s = 3'd0;
		if (fin) begin
			entry_d = entry_q + 16'd1;
			if (rem_q[cs] != 16'd0) rem_d[cs] = rem_q[cs] - 16'd1;
			if (rem_d[cs] == 16'd0) begin
				hdr_enter = 1'b1;
				first_s = {1'b0, cs} + 3'd1;
			end else begin
				phase_d = PH_NAME;
				bif_d = '0;
				lab_d = '0;
				nbs_d = '0;
				acc_d = '0;
			end
		end
		if (hdr_enter) begin
			found = 1'b0;
			phase_d = PH_DONE;
			bif_d = '0;
			for (s = 3'd0; s < 3'd4; s++) begin
				if (!found && s >= first_s && rem_d[s[1:0]] != 16'd0) begin
					found = 1'b1;
					sec_d = s[1:0];
					entry_d = '0;
					phase_d = PH_NAME;
					lab_d = '0;
					nbs_d = '0;
					acc_d = '0;
				end
			end
		end

		tag.message_done = (phase_d == PH_DONE);
		if (in_last) begin
			if (phase_d != PH_DONE) tag.status = ST_TRUNC;
			phase_d = PH_HDR;
			bif_d = '0;
			acc_d = '0;
			for (int i = 0; i < 4; i++) rem_d[i] = '0;
			entry_d = '0;
			lab_d = '0;
			nbs_d = '0;
			drem_d = '0;
			sec_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			bif_q <= '0;
			acc_q <= '0;
			for (int i = 0; i < 4; i++) rem_q[i] <= '0;
			entry_q <= '0;
			lab_q <= '0;
			nbs_q <= '0;
			drem_q <= '0;
			sec_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bif_q <= bif_d;
			acc_q <= acc_d;
			rem_q <= rem_d;
			entry_q <= entry_d;
			lab_q <= lab_d;
			nbs_q <= nbs_d;
			drem_q <= drem_d;
			sec_q <= sec_d;
		end
	end
endmodule

### sv/dnsp_queue.sv
// Short FIFO between the classifier and the output stage.
// Depends on dnsp_pkg.
module dnsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dnsp_pkg::tag_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output dnsp_pkg::tag_t rd_data,
	output logic           empty
);
	import dnsp_pkg::*;

	tag_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### sv/dnsp_back.sv
// Output stage: holds one tagged byte in a register and drives the result stream.
// Depends on dnsp_pkg.
module dnsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dnsp_pkg::tag_t q_data,
	output logic           q_pop,
	output logic           tvalid,
	input  logic           tready,
	output dnsp_pkg::tag_t tag
);
	import dnsp_pkg::*;

	logic valid_q;
	tag_t tag_q;

	assign q_pop = !q_empty && (!valid_q || tready);
	assign tvalid = valid_q;
	assign tag = tag_q;

	always_ff @(posedge clk) begin
		if (q_pop) tag_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end
endmodule

### sv/dns_message_field_parser.sv
// DNS message field parser, top level.
// Depends on dnsp_pkg, dnsp_front, dnsp_queue, dnsp_back.
//
// Usage:
//  - Slave stream: one message byte per request in s_tdata, s_tlast on the
//    final byte of the message. The state returns to the header after it.
//  - Master stream: one tagged result per input byte, in order.
//  - The classifier tags a byte in the cycle it is accepted and writes it
//    into a four-entry queue; an output register drives the master side.
//  - Path: each accepted byte's tag is registered in the queue and then in the
//    output register, which raises m_tvalid for it.
//  - Throughput: one byte per cycle sustained while m_tready is high.
//  - When the receiver stalls, the queue fills; s_tready drops only once
//    the queue is full, so up to four results plus the output register wait.
//  - Reset clears the parse state, the queue pointers and the output valid.
//  - Names longer than MAX_NAME_BYTES get status 2; a message ending early
//    gets status 1 on its last byte.
module dns_message_field_parser #(
	parameter int MAX_NAME_BYTES = dnsp_pkg::MAX_NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] section, [6:3] field_kind, [7] value_valid, [39:8] field_value,
	// [55:40] record_index, [56] record_end, [57] name_pointer,
	// [58] message_done, [60:59] status, [63:61] zero
	output logic [63:0] m_tdata
);
	import dnsp_pkg::*;

	tag_t fr_tag;
	tag_t q_out;
	tag_t o_tag;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic step;

	assign s_tready = !q_full;
	assign step = s_tvalid && s_tready;

	dnsp_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .step(step),
		.in_byte(s_tdata), .in_last(s_tlast), .tag(fr_tag)
	);

	dnsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(step), .wr_data(fr_tag),
		.full(q_full), .rd_en(q_pop), .rd_data(q_out), .empty(q_empty)
	);

	dnsp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_out),
		.q_pop(q_pop), .tvalid(m_tvalid), .tready(m_tready), .tag(o_tag)
	);

	assign m_tdata = {3'd0, o_tag.status, o_tag.message_done, o_tag.name_pointer,
		o_tag.record_end, o_tag.record_index, o_tag.field_value, o_tag.value_valid,
		o_tag.field_kind, o_tag.section};
endmodule

### bench/testbench.sv
// Testbench for dns_message_field_parser: byte stream in, one tag per byte out.
// Depends on dnsp_pkg and the parser RTL; self-checking against an inline predictor.
`timescale 1ns / 100ps

module testbench;
	import dnsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 100;
	localparam logic [3:0] FK_ID = 4'd0;
	localparam logic [3:0] FK_QD = 4'd2;
	localparam logic [2:0] SEC_ANSWER = 3'd2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	always #5 clk = ~clk;

	dns_message_field_parser dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	phase_t      ph;
	int          bif;
	logic [31:0] acc;
	logic [15:0] rem [4];
	logic [15:0] ent;
	int          lab;
	int          nseen;
	logic [15:0] drem;
	int          csec;

	tag_t pending_tags [$];
	int   errors = 0;
	int   sent = 0;
	bit   burst_mode = 0;

	function automatic void parse_reset();
		ph = PH_HDR; bif = 0; acc = '0; ent = '0; lab = 0; nseen = 0;
		drem = '0; csec = 0;
		for (int s = 0; s < 4; s++) rem[s] = '0;
	endfunction

	function automatic void start_name();
		ph = PH_NAME; bif = 0; lab = 0; nseen = 0; acc = '0;
	endfunction

	// first section at or after 'first' with entries left, else done
	function automatic void open_section(int first);
		for (int s = first; s < 4; s++) begin
			if (rem[s] != 0) begin
				csec = s; ent = '0; start_name();
				return;
			end
		end
		ph = PH_DONE; bif = 0;
	endfunction

	function automatic void close_record();
		ent = ent + 16'd1;
		if (rem[csec] != 0) rem[csec] = rem[csec] - 16'd1;
		if (rem[csec] == 0) open_section(csec + 1);
		else start_name();
	endfunction

	function automatic tag_t tag_byte(logic [7:0] b, logic last);
		tag_t t;
		int   need;
		t = '0;
		case (ph)
			PH_HDR: begin
				t.field_kind = 4'(bif >> 1);
				if (bif % 2 == 0) begin
					acc = {24'd0, b};
				end else begin
					acc = ((acc << 8) | b) & 32'hffff;
					t.value_valid = 1'b1;
					t.field_value = acc;
					if (bif >= 3) rem[((bif >> 1) - 2) & 3] = acc[15:0];
				end
				bif++;
				if (bif >= 12) open_section(0);
			end
			PH_NAME: begin
				t.section = 3'(csec + 1);
				t.field_kind = FK_NAME;
				t.record_index = ent;
				if (nseen >= MAX_NAME_BYTES_DEF) t.status = ST_LONG;
				if (nseen < 511) nseen++;
				if (bif == 1) begin
					t.name_pointer = 1'b1; ph = PH_TYPE; bif = 0;
				end else if (lab > 0) begin
					lab--;
				end else if (b == 8'd0) begin
					ph = PH_TYPE; bif = 0;
				end else if ((b & PTR_MARK) == PTR_MARK) begin
					t.name_pointer = 1'b1; bif = 1;
				end else begin
					lab = b & 8'h3f;
				end
			end
			PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
				t.section = 3'(csec + 1);
				t.record_index = ent;
				t.field_kind = (ph == PH_TYPE) ? FK_TYPE : (ph == PH_CLASS) ? FK_CLASS :
					(ph == PH_TTL) ? FK_TTL : FK_RDLEN;
				need = (ph == PH_TTL) ? 4 : 2;
				acc = (bif == 0) ? {24'd0, b} : ((acc << 8) | b);
				bif++;
				if (bif >= need) begin
					t.value_valid = 1'b1;
					t.field_value = acc;
					bif = 0;
					case (ph)
						PH_TYPE: ph = PH_CLASS;
						PH_CLASS: begin
							if (csec == 0) begin
								t.record_end = 1'b1; close_record();
							end else ph = PH_TTL;
						end
						PH_TTL: ph = PH_RDLEN;
						default: begin
							drem = acc[15:0];
							if (drem == 0) begin
								t.record_end = 1'b1; close_record();
							end else ph = PH_RDATA;
						end
					endcase
				end
			end
			PH_RDATA: begin
				t.section = 3'(csec + 1);
				t.field_kind = FK_RDATA;
				t.record_index = ent;
				if (drem != 0) drem = drem - 16'd1;
				if (drem == 0) begin
					t.record_end = 1'b1; close_record();
				end
			end
			default: begin
				t.section = SEC_TRAIL;
				t.field_kind = FK_EXTRA;
				ph = PH_DONE;
			end
		endcase
		t.message_done = (ph == PH_DONE);
		if (last) begin
			if (!t.message_done) t.status = ST_TRUNC;
			parse_reset();
		end
		return t;
	endfunction

	// ---------------- sender ----------------
	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         fixed;   // expectation typed in below
		tag_t       tag;
	} stim_row_t;

	stim_row_t directed_rows [$];

	function automatic tag_t mk_tag(logic [2:0] sec, logic [3:0] kind, logic vv,
			logic [31:0] val, logic rend, logic done, logic [1:0] st);
		tag_t t;
		t = '0;
		t.section = sec; t.field_kind = kind; t.value_valid = vv; t.field_value = val;
		t.record_end = rend; t.message_done = done; t.status = st;
		return t;
	endfunction

	function automatic void add_row(logic [7:0] b, logic last, bit fixed = 0,
			tag_t tag = '0);
		stim_row_t r;
		r.b = b; r.last = last; r.fixed = fixed; r.tag = tag;
		directed_rows.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (burst_mode || r < 60) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_byte(logic [7:0] b, logic last, bit fixed, tag_t tag);
		int   gap;
		tag_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predicted = tag_byte(b, last);
		pending_tags.push_back(fixed ? tag : predicted);
		sent++;
	endtask

	// ---------------- random message builder ----------------
	logic [7:0] msg [$];

	function automatic void put16(logic [15:0] v);
		msg.push_back(v[15:8]); msg.push_back(v[7:0]);
	endfunction

	function automatic void put_name(bit too_long);
		int n_labels, len;
		logic [7:0] lb;
		n_labels = too_long ? 5 : $urandom_range(3);
		for (int i = 0; i < n_labels; i++) begin
			len = too_long ? 63 : $urandom_range(8, 1);
			lb = 8'(len);
			// reserved label types still carry a 6-bit length
			case ($urandom_range(9))
				0: lb = lb | 8'h40;
				1: lb = lb | 8'h80;
				default: ;
			endcase
			msg.push_back(lb);
			for (int k = 0; k < len; k++) msg.push_back(8'($urandom));
		end
		if ($urandom_range(9) < 7) msg.push_back(8'h00);
		else begin
			msg.push_back(PTR_MARK | 8'($urandom_range(63)));
			msg.push_back(8'($urandom));
		end
	endfunction

	function automatic void build_message(bit force_long);
		logic [15:0] cnt [4];
		int          n, rdlen, long_at, r;
		bit          long_used;
		msg.delete();
		r = $urandom_range(99);
		if (r < 5) begin
			// noise: junk ending anywhere
			n = $urandom_range(20, 1);
			for (int i = 0; i < n; i++) msg.push_back(8'($urandom));
			return;
		end
		put16(16'($urandom)); put16(16'($urandom));
		for (int s = 0; s < 4; s++) begin
			cnt[s] = ($urandom_range(9) < 4) ? 16'd0 : 16'($urandom_range(3, 1));
			if ($urandom_range(99) < 4) cnt[s] = 16'($urandom);
			put16(cnt[s]);
		end
		long_at = force_long ? $urandom_range(3) : -1;
		long_used = 0;
		for (int s = 0; s < 4; s++) begin
			n = (cnt[s] > 3) ? 3 : cnt[s];
			for (int e = 0; e < n; e++) begin
				put_name(!long_used && s >= long_at && long_at >= 0);
				if (s >= long_at && long_at >= 0) long_used = 1;
				put16(16'($urandom)); put16(16'($urandom));
				if (s > 0) begin
					put16(16'($urandom)); put16(16'($urandom));
					rdlen = ($urandom_range(9) < 2) ? 0 : $urandom_range(6, 1);
					put16(16'(rdlen));
					for (int k = 0; k < rdlen; k++) msg.push_back(8'($urandom));
				end
			end
		end
		if ($urandom_range(9) < 3) begin
			n = $urandom_range(3, 1);
			for (int i = 0; i < n; i++) msg.push_back(8'($urandom));
		end
		// broken message: cut short
		if ($urandom_range(99) < 15 && msg.size() > 1) begin
			n = $urandom_range(msg.size() - 1, 1);
			while (msg.size() > n) void'(msg.pop_back());
		end
	endfunction

	// ---------------- stimulus ----------------
	initial begin : stimulus
		int n_msgs;
		parse_reset();
		// truncated header
		add_row(8'h12, 1'b0, 1, mk_tag(SEC_HDR, FK_ID, 1'b0, 32'd0, 1'b0, 1'b0, ST_OK));
		add_row(8'h34, 1'b1, 1,
			mk_tag(SEC_HDR, FK_ID, 1'b1, 32'h1234, 1'b0, 1'b0, ST_TRUNC));
		// AN=1: pointer name, all-ones ttl, zero rdlength, then a trailing byte
		add_row(8'hff, 1'b0); add_row(8'hff, 1'b0);
		add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0, 1, mk_tag(SEC_HDR, FK_QD, 1'b1, 32'd0, 1'b0, 1'b0, ST_OK));
		add_row(8'h00, 1'b0); add_row(8'h01, 1'b0);
		add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
		add_row(8'hff, 1'b0); add_row(8'h0c, 1'b0);
		add_row(8'h00, 1'b0); add_row(8'h01, 1'b0);
		add_row(8'h00, 1'b0); add_row(8'h01, 1'b0);
		add_row(8'hff, 1'b0); add_row(8'hff, 1'b0); add_row(8'hff, 1'b0);
		add_row(8'hff, 1'b0, 1,
			mk_tag(SEC_ANSWER, FK_TTL, 1'b1, 32'hffff_ffff, 1'b0, 1'b0, ST_OK));
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0, 1,
			mk_tag(SEC_ANSWER, FK_RDLEN, 1'b1, 32'd0, 1'b1, 1'b1, ST_OK));
		add_row(8'haa, 1'b1, 1,
			mk_tag(SEC_TRAIL, FK_EXTRA, 1'b0, 32'd0, 1'b0, 1'b1, ST_OK));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].last,
				directed_rows[i].fixed, directed_rows[i].tag);

		n_msgs = 0;
		while (sent < 400) begin
			build_message(n_msgs == 0 || n_msgs == 9);
			burst_mode = ($urandom_range(4) == 0);
			foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 0, '0);
			n_msgs++;
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (pending_tags.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// ---------------- receiver ----------------
	initial begin : receiver
		bit held;
		int r;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && sent >= 150) begin
				// long hold-off: queue fills and s_tready must drop
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (sent % 200 < 40) m_tready <= 1'b1;
				else if (r < 3) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(30, 10)) @(posedge clk);
					m_tready <= 1'b1;
				end else m_tready <= (r < 75);
			end
		end
	end

	task automatic report_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tag_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.section = m_tdata[2:0];
			got.field_kind = m_tdata[6:3];
			got.value_valid = m_tdata[7];
			got.field_value = m_tdata[39:8];
			got.record_index = m_tdata[55:40];
			got.record_end = m_tdata[56];
			got.name_pointer = m_tdata[57];
			got.message_done = m_tdata[58];
			got.status = m_tdata[60:59];
			if (pending_tags.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_tags.pop_front();
				report_field("section", {29'd0, want.section}, {29'd0, got.section});
				report_field("field_kind", {28'd0, want.field_kind},
					{28'd0, got.field_kind});
				report_field("value_valid", {31'd0, want.value_valid},
					{31'd0, got.value_valid});
				report_field("field_value", want.field_value, got.field_value);
				report_field("record_index", {16'd0, want.record_index},
					{16'd0, got.record_index});
				report_field("record_end", {31'd0, want.record_end},
					{31'd0, got.record_end});
				report_field("name_pointer", {31'd0, want.name_pointer},
					{31'd0, got.name_pointer});
				report_field("message_done", {31'd0, want.message_done},
					{31'd0, got.message_done});
				report_field("status", {30'd0, want.status}, {30'd0, got.status});
				report_field("pad", 32'd0, {29'd0, m_tdata[63:61]});
			end
		end
	end

	// ends the run if no request moves on either side for too long
	always @(posedge clk) begin : watchdog
		int idle;
		if (!arst_n) idle = 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
		else begin
			idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("testbench failed");
				$finish;
			end
		end
	end

endmodule

### filelist.f
sv/dnsp_pkg.sv
sv/dnsp_front.sv
sv/dnsp_queue.sv
sv/dnsp_back.sv
sv/dns_message_field_parser.sv
bench/testbench.sv
